FILE: hdl/nasee_pkg.sv
// Package for the nested add/subtract expression evaluator.
// Holds the character codes, skip lengths, status codes and default sizes.
// No dependencies.
`default_nettype none

package nasee_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int DATA_W = 32;
  localparam int CHAR_W = 8;
  localparam int SKIP_W = 4;

  localparam logic [CHAR_W-1:0] CH_ADD   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_SUB   = 8'h73;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Characters that follow the operator letter and are not looked at.
  localparam logic [SKIP_W-1:0] SKIP_ADD = 4'd3;
  localparam logic [SKIP_W-1:0] SKIP_SUB = 4'd8;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/nasee_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for both stacks of the expression evaluator. No dependencies.
`default_nettype none

module nasee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wen,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/nested_add_sub_expression_evaluator_unit.sv
// Top level of the nested add/subtract expression evaluator.
// Depends on nasee_pkg and nasee_ram.
//
//   Channel  Handshake                  Payload                 Moves per transaction
//   char     char_valid / char_stall    char_code, last_char    one input character
//   result   result_valid / result_stall result_value, status   one evaluated expression
//
// One character is taken every cycle while char_stall is low; each is handled in the cycle it is accepted.
// A result is written into the output register when its last character is accepted.
// char_stall is high only while a finished result waits and result_stall is high.
// The stack tops live in registers; each RAM read port always fetches the entry
// under the top, so back-to-back closing parentheses run at full rate.
// Synchronous reset clears counts and flags; the stack RAMs need no clearing pass.
`default_nettype none

module nested_add_sub_expression_evaluator_unit #(
  parameter int STACK_DEPTH = nasee_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                char_valid,
  output logic                                     char_stall,
  input  wire logic [nasee_pkg::CHAR_W-1:0]        char_code,
  input  wire logic                                last_char,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output logic signed [nasee_pkg::DATA_W-1:0]      result_value,
  output nasee_pkg::status_t                       status
);

  import nasee_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // Evaluator state.
  logic [CW-1:0]     vcount, vcount_next;
  logic [CW-1:0]     ocount, ocount_next;
  logic [DATA_W-1:0] top, top_next;
  logic              op_top, op_top_next;
  logic [DATA_W-1:0] accum, accum_next;
  logic              in_num, in_num_next;
  logic [SKIP_W-1:0] skip, skip_next;
  status_t           err, err_next;

  // RAM ports.
  logic              vwen, owen;
  logic [AW-1:0]     vwaddr, owaddr, vraddr, oraddr;
  logic [DATA_W-1:0] vwdata, vrdata;
  logic              owdata, ordata;

  logic              accept;
  logic              is_digit;
  logic [CW-1:0]     vbelow, obelow;
  logic [DATA_W-1:0] out_value;
  status_t           out_status;

  assign accept     = char_valid && !char_stall;
  assign char_stall = result_valid && result_stall;
  assign is_digit   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);

  always_comb begin
    logic [CW-1:0]     vc_mid;
    logic [CW-1:0]     vc_low;
    logic              num_pushed;
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
    logic [DATA_W-1:0] group_val;
    logic [CHAR_W-1:0] digit_val;

    vcount_next = vcount;
    ocount_next = ocount;
    top_next    = top;
    op_top_next = op_top;
    accum_next  = accum;
    in_num_next = in_num;
    skip_next   = skip;
    err_next    = err;
    vwen        = 1'b0;
    vwaddr      = vcount[AW-1:0];
    vwdata      = accum;
    owen        = 1'b0;
    owaddr      = ocount[AW-1:0];
    owdata      = (char_code == CH_SUB);
    out_value   = '0;
    out_status  = ST_OK;
    vc_mid      = vcount;
    vc_low      = vcount - CW'(2);
    num_pushed  = 1'b0;
    left        = vrdata;
    right       = top;
    group_val   = '0;
    digit_val   = char_code - CH_ZERO;

    if (accept) begin
      if (skip != '0) begin
        skip_next = skip - SKIP_W'(1);
      end else if (is_digit) begin
        accum_next  = (accum << 3) + (accum << 1) + {{(DATA_W-4){1'b0}}, digit_val[3:0]};
        in_num_next = 1'b1;
      end else begin
        // Any other character first ends a pending digit run.
        if (in_num) begin
          accum_next  = '0;
          in_num_next = 1'b0;
          if (vcount == CW'(STACK_DEPTH)) begin
            if (err == ST_OK) begin
              err_next = ST_OVER;
            end
          end else begin
            vwen       = 1'b1;
            vwaddr     = vcount[AW-1:0];
            vwdata     = accum;
            top_next   = accum;
            vc_mid     = vcount + CW'(1);
            num_pushed = 1'b1;
          end
        end
        vcount_next = vc_mid;

        if (char_code == CH_ADD || char_code == CH_SUB) begin
          skip_next = (char_code == CH_SUB) ? SKIP_SUB : SKIP_ADD;
          if (ocount == CW'(STACK_DEPTH)) begin
            if (err_next == ST_OK) begin
              err_next = ST_OVER;
            end
          end else begin
            owen        = 1'b1;
            owaddr      = ocount[AW-1:0];
            owdata      = (char_code == CH_SUB);
            op_top_next = (char_code == CH_SUB);
            ocount_next = ocount + CW'(1);
          end
        end else if (char_code == CH_CLOSE) begin
          if (vc_mid < CW'(2) || ocount == '0) begin
            if (err_next == ST_OK) begin
              err_next = ST_UNDER;
            end
          end else begin
            // A number pushed by this same character sits above the old top.
            left        = num_pushed ? top : vrdata;
            right       = num_pushed ? accum : top;
            group_val   = op_top ? (left - right) : (left + right);
            vc_low      = vc_mid - CW'(2);
            vwen        = 1'b1;
            vwaddr      = vc_low[AW-1:0];
            vwdata      = group_val;
            top_next    = group_val;
            vcount_next = vc_mid - CW'(1);
            ocount_next = ocount - CW'(1);
            op_top_next = ordata;
          end
        end
      end

      if (last_char) begin
        if (err_next != ST_OK) begin
          out_status = err_next;
        end else if (in_num_next) begin
          out_value = accum_next;
        end else if (vcount_next != '0) begin
          out_value = top_next;
        end else begin
          out_status = ST_EMPTY;
        end
        vcount_next = '0;
        ocount_next = '0;
        accum_next  = '0;
        in_num_next = 1'b0;
        skip_next   = '0;
        err_next    = ST_OK;
      end
    end
  end

  // Each read port fetches the entry just under the top for the next cycle.
  assign vbelow = vcount_next - CW'(2);
  assign obelow = ocount_next - CW'(2);
  assign vraddr = vbelow[AW-1:0];
  assign oraddr = obelow[AW-1:0];

  nasee_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_value_ram (
    .clk  (clk),
    .wen  (vwen),
    .waddr(vwaddr),
    .wdata(vwdata),
    .raddr(vraddr),
    .rdata(vrdata)
  );

  nasee_ram #(
    .WIDTH(1),
    .DEPTH(STACK_DEPTH)
  ) u_op_ram (
    .clk  (clk),
    .wen  (owen),
    .waddr(owaddr),
    .wdata(owdata),
    .raddr(oraddr),
    .rdata(ordata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount       <= '0;
      ocount       <= '0;
      accum        <= '0;
      in_num       <= 1'b0;
      skip         <= '0;
      err          <= ST_OK;
      result_valid <= 1'b0;
    end else begin
      vcount <= vcount_next;
      ocount <= ocount_next;
      accum  <= accum_next;
      in_num <= in_num_next;
      skip   <= skip_next;
      err    <= err_next;
      if (accept && last_char) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top    <= top_next;
    op_top <= op_top_next;
    if (accept && last_char) begin
      result_value <= $signed(out_value);
      status       <= out_status;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && last_char |=> vcount == '0 && ocount == '0 && skip == '0 && !in_num)
    else $error("state not cleared after the final character");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(accept && last_char))
    else $error("result appeared without a final character");

  a_error_value_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_OK |-> result_value == '0)
    else $error("nonzero value with an error status");

  a_skip_no_number: assert property (@(posedge clk) disable iff (rst)
    skip != '0 |-> !in_num)
    else $error("digit run pending while skipping");

endmodule

`default_nettype wire

FILE: test/nasee_checker.sv
// Checker for the nested add/subtract expression evaluator: watches both channels,
// predicts each expression's result from the accepted characters and compares it.
// Depends on nasee_pkg.
`timescale 1ns / 100ps

module nasee_checker #(
  parameter int STACK_DEPTH = nasee_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                char_valid,
  input  wire logic                                char_stall,
  input  wire logic [nasee_pkg::CHAR_W-1:0]        char_code,
  input  wire logic                                last_char,
  input  wire logic                                result_valid,
  input  wire logic                                result_stall,
  input  wire logic signed [nasee_pkg::DATA_W-1:0] result_value,
  input  wire nasee_pkg::status_t                  status,
  output int                                       fail_count,
  output int                                       pending,
  output int                                       results_checked,
  output logic [3:0]                               statuses_seen
);
  import nasee_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_t           code;
  } outcome_t;

  outcome_t          expected_q[$];
  logic [DATA_W-1:0] value_stk [STACK_DEPTH];
  bit                op_is_sub [STACK_DEPTH];
  int unsigned       n_values;
  int unsigned       n_ops;
  logic [DATA_W-1:0] digits_acc;
  bit                digits_open;
  int unsigned       skip_count;
  status_t           sticky;

  function automatic void clear_state();
    n_values = 0;
    n_ops = 0;
    digits_acc = '0;
    digits_open = 1'b0;
    skip_count = 0;
    sticky = ST_OK;
  endfunction

  // Only the first error of an expression is reported.
  function automatic void note_error(status_t code);
    if (sticky == ST_OK) sticky = code;
  endfunction

  function automatic void push_value(logic [DATA_W-1:0] v);
    if (n_values >= STACK_DEPTH) begin
      note_error(ST_OVER);
    end else begin
      value_stk[n_values] = v;
      n_values++;
    end
  endfunction

  function automatic void push_op(bit is_sub);
    if (n_ops >= STACK_DEPTH) begin
      note_error(ST_OVER);
    end else begin
      op_is_sub[n_ops] = is_sub;
      n_ops++;
    end
  endfunction

  function automatic void take_char(logic [CHAR_W-1:0] c, logic is_last);
    outcome_t          o;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    if (skip_count != 0) begin
      skip_count--;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      digits_acc = digits_acc * 10 + (c - CH_ZERO);
      digits_open = 1'b1;
    end else begin
      if (digits_open) begin
        push_value(digits_acc);
        digits_acc = '0;
        digits_open = 1'b0;
      end
      if (c == CH_ADD) begin
        push_op(1'b0);
        skip_count = SKIP_ADD;
      end else if (c == CH_SUB) begin
        push_op(1'b1);
        skip_count = SKIP_SUB;
      end else if (c == CH_CLOSE) begin
        if (n_values < 2 || n_ops < 1) begin
          note_error(ST_UNDER);
        end else begin
          rhs = value_stk[n_values-1];
          lhs = value_stk[n_values-2];
          n_values -= 2;
          n_ops--;
          push_value(op_is_sub[n_ops] ? lhs - rhs : lhs + rhs);
        end
      end
    end
    if (is_last) begin
      o.value = '0;
      if (sticky != ST_OK) begin
        o.code = sticky;
      end else if (digits_open) begin
        o.value = digits_acc;
        o.code = ST_OK;
      end else if (n_values != 0) begin
        o.value = value_stk[n_values-1];
        o.code = ST_OK;
      end else begin
        o.code = ST_EMPTY;
      end
      expected_q.push_back(o);
      clear_state();
    end
  endfunction

  function automatic void check_result();
    outcome_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result transaction: value %0d status %0d",
               $time, result_value, status);
      fail_count++;
    end else begin
      want = expected_q.pop_front();
      results_checked++;
      statuses_seen[want.code] = 1'b1;
      if (result_value !== want.value) begin
        $display("%0t: result_value mismatch: expected %0d, actual %0d",
                 $time, $signed(want.value), result_value);
        fail_count++;
      end
      if (status !== want.code) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.code, status);
        fail_count++;
      end
    end
  endfunction

  // A result is registered when its last character is accepted and leaves the output register at a later edge, so
  // the result is checked before a character accepted at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_q.delete();
      fail_count = 0;
      results_checked = 0;
      statuses_seen = '0;
    end else begin
      if (result_valid && !result_stall) check_result();
      if (char_valid && !char_stall) take_char(char_code, last_char);
    end
    pending <= expected_q.size();
  end

endmodule

FILE: test/tb.sv
// Testbench top for the nested add/subtract expression evaluator: drives character
// streams of directed and random expressions and gives the verdict.
// Depends on nasee_pkg, nested_add_sub_expression_evaluator_unit and nasee_checker.
`timescale 1ns / 100ps

module tb;
  import nasee_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     char_valid = 1'b0;
  logic                     char_stall;
  logic [CHAR_W-1:0]        char_code = '0;
  logic                     last_char = 1'b0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic signed [DATA_W-1:0] result_value;
  status_t                  status;

  int          fail_count;
  int          pending;
  int          results_checked;
  logic [3:0]  statuses_seen;

  logic [CHAR_W-1:0] text[$];
  bit          calm = 1'b0;
  int          hold_request = 0;
  int          hold_served = 0;
  int          stall_run = 0;
  int          chars_sent = 0;
  int          exprs_sent = 0;
  int          quiet_cycles = 0;

  nested_add_sub_expression_evaluator_unit #(.STACK_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .char_valid(char_valid), .char_stall(char_stall),
    .char_code(char_code), .last_char(last_char),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_value(result_value), .status(status)
  );

  nasee_checker #(.STACK_DEPTH(DEPTH)) checker_i (
    .clk(clk), .rst(rst),
    .char_valid(char_valid), .char_stall(char_stall),
    .char_code(char_code), .last_char(last_char),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_value(result_value), .status(status),
    .fail_count(fail_count), .pending(pending),
    .results_checked(results_checked), .statuses_seen(statuses_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, or a long hold-off when the stimulus asks for one.
  always @(posedge clk) begin
    if (stall_run != 0) begin
      result_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if (hold_served != hold_request) begin
      hold_served <= hold_request;
      stall_run <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(99) < 20);
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void put_word(string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endfunction

  // Mostly short numbers; now and then long enough to wrap past 32 bits.
  function automatic void put_number();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(3, 1);
    repeat (len) text.push_back(CH_ZERO + CHAR_W'($urandom_range(9)));
  endfunction

  function automatic void put_expr(int depth);
    bit is_sub;
    if (depth == 0 || $urandom_range(99) < 30) begin
      put_number();
    end else begin
      is_sub = $urandom_range(1);
      put_word(is_sub ? "subtract(" : "add(");
      put_expr(depth - 1);
      text.push_back(CH_COMMA);
      if ($urandom_range(9) == 0) text.push_back(CH_SPACE);
      put_expr(depth - 1);
      text.push_back(CH_CLOSE);
    end
  endfunction

  function automatic void make_expression();
    int kind;
    int keep;
    text.delete();
    kind = $urandom_range(99);
    if (kind < 65) begin
      put_expr($urandom_range(5));
    end else if (kind < 73) begin
      // Cut short: the last character may fall in a skipped word or a digit run.
      put_expr($urandom_range(5, 1));
      keep = (text.size() > 1) ? $urandom_range(text.size() - 1, 1) : 1;
      while (text.size() > keep) void'(text.pop_back());
    end else if (kind < 79) begin
      put_expr($urandom_range(4));
      text.insert($urandom_range(text.size()), CH_CLOSE);
    end else if (kind < 84) begin
      put_expr($urandom_range(4, 1));
      text[$urandom_range(text.size() - 1)] = CHAR_W'($urandom_range(255));
    end else if (kind < 89) begin
      repeat ($urandom_range(12, 1)) text.push_back(CHAR_W'($urandom_range(255)));
    end else if (kind < 93) begin
      // Value stack filled from just under its depth up to and past it.
      repeat ($urandom_range(DEPTH + 6, DEPTH - 1)) begin
        put_number();
        text.push_back(CH_COMMA);
      end
    end else if (kind < 96) begin
      // Operator stack filled from just under its depth up to and past it.
      repeat ($urandom_range(DEPTH + 3, DEPTH - 1))
        put_word($urandom_range(1) ? "subtract(" : "add(");
      put_number();
      if ($urandom_range(1)) text.push_back(CH_CLOSE);
    end else begin
      case ($urandom_range(3))
        0: text.push_back(CH_COMMA);
        1: text.push_back(CH_ZERO + CHAR_W'($urandom_range(9)));
        2: text.push_back(CH_CLOSE);
        default: text.push_back(CH_ADD);
      endcase
    end
  endfunction

  // The last character of the text carries last_char.
  task automatic send_text();
    for (int i = 0; i < text.size(); i++) begin
      while (!calm && $urandom_range(99) < 20) begin
        char_valid <= 1'b0;
        @(posedge clk);
      end
      char_valid <= 1'b1;
      char_code <= text[i];
      last_char <= (i == text.size() - 1);
      do @(posedge clk); while (char_stall);
      chars_sent++;
    end
    exprs_sent++;
  endtask

  task automatic wait_drained();
    char_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int round;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: close with nothing open, unknown bytes only, add, negative
    // subtract, and a bare number.
    text.delete();
    text.push_back(CH_CLOSE);
    send_text();
    text.delete();
    text.push_back(8'h00);
    text.push_back(8'hFF);
    send_text();
    text.delete();
    put_word("add(7,5)");
    send_text();
    text.delete();
    put_word("subtract(4,9)");
    send_text();
    text.delete();
    put_word("0");
    send_text();
    wait_drained();

    round = 0;
    while (chars_sent < 2000 || exprs_sent < 60) begin
      if (round == 15) calm <= 1'b1;
      if (round == 30) calm <= 1'b0;
      if (round == 40) begin
        // Hold the result side off while short expressions keep coming, so the
        // output register fills and the character side stalls.
        hold_request <= hold_request + 1;
        repeat (8) begin
          text.delete();
          put_number();
          send_text();
        end
      end
      if (round % 20 == 19) wait_drained();
      make_expression();
      send_text();
      round++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Summary: %0d characters in %0d expressions, %0d results checked;",
             chars_sent, exprs_sent, results_checked);
    $display("status codes seen (one bit per code, empty..ok): %b", statuses_seen);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: nested_add_sub_expression_evaluator_unit.f
hdl/nasee_pkg.sv
hdl/nasee_ram.sv
hdl/nested_add_sub_expression_evaluator_unit.sv
test/nasee_checker.sv
test/tb.sv
